// ===== rtl/core/abg_pkg.sv =====
// ----------------------------------------------------------------------------
// abg_pkg
// Shared types and constants for the register bridge core.
// ----------------------------------------------------------------------------
package abg_pkg;

	// Host and controller access codes
	typedef enum logic [3:0] {
		CMD_KBD_RD    = 4'd0,
		CMD_CLR_STB   = 4'd1,
		CMD_ANYKEY_RD = 4'd2,
		CMD_MOUSE_RD  = 4'd3,
		CMD_MODS_RD   = 4'd4,
		CMD_DATA_RD   = 4'd5,
		CMD_STAT_RD   = 4'd6,
		CMD_STAT_WR   = 4'd7,
		CMD_CMD_WR    = 4'd8,
		CMD_PORT_WR   = 4'd9,
		CMD_PORT_RD   = 4'd10
	} cmd_t;

	// Controller ports
	localparam logic [1:0] PORT_LATCH = 2'd0;
	localparam logic [1:0] PORT_ID    = 2'd1;
	localparam logic [1:0] PORT_SEL   = 2'd2;
	localparam logic [1:0] PORT_MOD   = 2'd3;
	localparam logic [7:0] PORT_ID_VALUE = 8'h06;

	// Register file indexes
	localparam logic [3:0] REG_KBD     = 4'd0;
	localparam logic [3:0] REG_CMD     = 4'd1;
	localparam logic [3:0] REG_MOUSE_X = 4'd2;
	localparam logic [3:0] REG_MOUSE_Y = 4'd3;
	localparam logic [3:0] REG_CTL     = 4'd4;
	localparam logic [3:0] REG_ANYKEY  = 4'd5;
	localparam logic [3:0] REG_MODS    = 4'd6;
	localparam logic [3:0] REG_DATA    = 4'd7;

	// Status byte bit positions
	localparam int ST_CMD_FULL   = 0;
	localparam int ST_Y_NEXT     = 1;
	localparam int ST_KBD_FULL   = 3;
	localparam int ST_DATA_VALID = 5;
	localparam int ST_MOUSE_FULL = 7;
	localparam logic [7:0] ST_WR_MASK = 8'h54;

	// Bit of the control register that lives outside the memory
	localparam int CTL_CMD_BIT = 6;

	typedef struct packed {
		logic       re;
		logic       we;
		logic [3:0] addr;
		logic [7:0] wdata;
	} mem_req_t;

	// Item information handed to the read stage
	typedef struct packed {
		logic       mem_rd;
		logic       kbd;
		logic       kbd_full;
		logic       ovl_ctl;
		logic       ctl_bit;
		logic       ld_latch;
		logic [7:0] rd;
		logic       line_release;
		logic       command_key;
		logic       option_key;
	} stage_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} latch_fwd_t;

endpackage

// ===== rtl/core/abg_regmem.sv =====
// ----------------------------------------------------------------------------
// abg_regmem
// Sixteen byte register file, one synchronous port, per-entry valid bits.
// ----------------------------------------------------------------------------
module abg_regmem (
	input  logic               clk,
	input  logic               arst_n,
	input  abg_pkg::mem_req_t  req,
	output logic [7:0]         rdata
);
	import abg_pkg::*;

	logic [7:0]  mem [16];
	logic [15:0] vld_q;
	logic [7:0]  rdata_q;
	logic        rvld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	// Unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= vld_q[req.addr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : 8'h00;

endmodule

// ===== rtl/core/abg_ctrl.sv =====
// ----------------------------------------------------------------------------
// abg_ctrl
// Access decode and flag state; issues at most one register file access per item.
// ----------------------------------------------------------------------------
module abg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  abg_pkg::cmd_t        cmd,
	input  logic [1:0]           port_number,
	input  logic [7:0]           value_in,
	input  logic                 latch_port_is_output,
	input  logic                 bus_line_level,
	input  abg_pkg::latch_fwd_t  fwd,
	output abg_pkg::mem_req_t    req,
	output abg_pkg::stage_t      info
);
	import abg_pkg::*;

	logic [7:0] status_q, status_d;
	logic       y_next_q, y_next_d;
	logic [7:0] latch_q;
	logic [3:0] sel_q, sel_d;
	logic       strobe_q, strobe_d;
	logic [1:0] mods_q, mods_d;
	logic       line_q, line_d;
	logic       ctl_bit_q, ctl_bit_d;
	logic [7:0] latch_eff;
	logic       latch_wr;
	mem_req_t   req_d;

	// Pending latch load from the read stage wins over the stored latch
	assign latch_eff = fwd.valid ? fwd.data : latch_q;

	always_comb begin
		status_d  = status_q;
		y_next_d  = y_next_q;
		sel_d     = sel_q;
		strobe_d  = strobe_q;
		mods_d    = mods_q;
		line_d    = line_q;
		ctl_bit_d = ctl_bit_q;
		latch_wr  = 1'b0;
		req_d     = '0;
		info      = '0;
		info.ctl_bit = ctl_bit_q;
		case (cmd)
			CMD_KBD_RD: begin
				req_d.re      = 1'b1;
				req_d.addr    = REG_KBD;
				info.mem_rd   = 1'b1;
				info.kbd      = 1'b1;
				info.kbd_full = status_q[ST_KBD_FULL];
			end
			CMD_CLR_STB: begin
				status_d[ST_KBD_FULL] = 1'b0;
			end
			CMD_ANYKEY_RD: begin
				req_d.re    = 1'b1;
				req_d.addr  = REG_ANYKEY;
				info.mem_rd = 1'b1;
			end
			CMD_MOUSE_RD: begin
				req_d.re    = 1'b1;
				req_d.addr  = y_next_q ? REG_MOUSE_Y : REG_MOUSE_X;
				info.mem_rd = 1'b1;
				if (y_next_q) begin
					status_d[ST_MOUSE_FULL] = 1'b0;
				end
				y_next_d = ~y_next_q;
			end
			CMD_MODS_RD: begin
				req_d.re    = 1'b1;
				req_d.addr  = REG_MODS;
				info.mem_rd = 1'b1;
			end
			CMD_DATA_RD: begin
				req_d.re    = 1'b1;
				req_d.addr  = REG_DATA;
				info.mem_rd = 1'b1;
				status_d[ST_DATA_VALID] = 1'b0;
			end
			CMD_STAT_RD: begin
				info.rd = status_q;
				info.rd[ST_Y_NEXT] = y_next_q;
			end
			CMD_STAT_WR: begin
				status_d = (status_q & ~ST_WR_MASK) | (value_in & ST_WR_MASK);
			end
			CMD_CMD_WR: begin
				req_d.we    = 1'b1;
				req_d.addr  = REG_CMD;
				req_d.wdata = value_in;
				ctl_bit_d   = 1'b1;
				status_d[ST_CMD_FULL] = 1'b1;
			end
			CMD_PORT_WR: begin
				case (port_number)
					PORT_LATCH: begin
						latch_wr = 1'b1;
					end
					PORT_SEL: begin
						sel_d = value_in[3:0];
						if (value_in[4] != strobe_q) begin
							strobe_d = value_in[4];
							// Falling strobe moves a byte between latch and register
							if (!value_in[4]) begin
								if (latch_port_is_output) begin
									req_d.we    = 1'b1;
									req_d.addr  = value_in[3:0];
									req_d.wdata = latch_eff;
									case (value_in[3:0])
										REG_KBD: status_d[ST_KBD_FULL] = 1'b1;
										REG_MOUSE_X, REG_MOUSE_Y: begin
											status_d[ST_MOUSE_FULL] = 1'b1;
											y_next_d = 1'b0;
										end
										REG_CTL: ctl_bit_d = latch_eff[CTL_CMD_BIT];
										REG_DATA: status_d[ST_DATA_VALID] = 1'b1;
										default: ;
									endcase
								end else begin
									req_d.re      = 1'b1;
									req_d.addr    = value_in[3:0];
									info.ld_latch = 1'b1;
									info.ovl_ctl  = (value_in[3:0] == REG_CTL);
									if (value_in[3:0] == REG_CMD) begin
										ctl_bit_d = 1'b0;
										status_d[ST_CMD_FULL] = 1'b0;
									end
								end
							end
						end
					end
					PORT_MOD: begin
						mods_d = value_in[5:4];
						line_d = ~value_in[3];
					end
					default: ;
				endcase
			end
			CMD_PORT_RD: begin
				case (port_number)
					PORT_LATCH: info.rd = latch_eff;
					PORT_ID:    info.rd = PORT_ID_VALUE;
					PORT_SEL:   info.rd = {bus_line_level, 7'd0};
					default:    info.rd = 8'h00;
				endcase
			end
			default: ;
		endcase
		info.line_release = line_d;
		info.command_key  = mods_d[1];
		info.option_key   = mods_d[0];
		if (!accept) begin
			req_d = '0;
		end
	end

	assign req = req_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= '0;
			y_next_q  <= 1'b0;
			latch_q   <= '0;
			sel_q     <= '0;
			strobe_q  <= 1'b0;
			mods_q    <= '0;
			line_q    <= 1'b1;
			ctl_bit_q <= 1'b0;
		end else begin
			if (accept) begin
				status_q  <= status_d;
				y_next_q  <= y_next_d;
				sel_q     <= sel_d;
				strobe_q  <= strobe_d;
				mods_q    <= mods_d;
				line_q    <= line_d;
				ctl_bit_q <= ctl_bit_d;
			end
			if (accept && latch_wr) begin
				latch_q <= value_in;
			end else if (fwd.valid) begin
				latch_q <= fwd.data;
			end
		end
	end

endmodule

// ===== rtl/core/adb_glue_register_bridge_core.sv =====
// ----------------------------------------------------------------------------
// adb_glue_register_bridge_core
// Host/controller register bridge built around a 16-byte register memory.
// Path: read stage (item and its memory read), then output register until taken.
// Throughput: one transfer per cycle while the output is not stalled; the
// single memory port takes at most one access per item. A stalled output
// holds two items before the input stalls.
// Reset: asynchronous; flags, latch, select and valid bits clear, line released.
// ----------------------------------------------------------------------------
module adb_glue_register_bridge_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] cmd, [5:4] port_number, [13:6] value_in,
	// [14] latch_port_is_output, [15] bus_line_level
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] read_data, [8] line_release, [9] command_key, [10] option_key,
	// [15:11] zero
	output logic [15:0] m_tdata
);
	import abg_pkg::*;

	logic       accept;
	logic       advance;
	logic       s1_adv;
	mem_req_t   req;
	stage_t     info;
	latch_fwd_t fwd;
	logic [7:0] mem_rdata;
	logic [7:0] mem_val;
	logic [7:0] rd_val;

	logic       valid_s1;
	stage_t     info_s1;

	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;

	// Output register frees up when empty or being taken
	assign advance  = ~m_tvalid_q | m_tready;
	assign s1_adv   = valid_s1 & advance;
	assign s_tready = ~valid_s1 | advance;
	assign accept   = s_tvalid & s_tready;

	abg_ctrl u_ctrl (
		.clk                  (clk),
		.arst_n               (arst_n),
		.accept               (accept),
		.cmd                  (cmd_t'(s_tdata[3:0])),
		.port_number          (s_tdata[5:4]),
		.value_in             (s_tdata[13:6]),
		.latch_port_is_output (s_tdata[14]),
		.bus_line_level       (s_tdata[15]),
		.fwd                  (fwd),
		.req                  (req),
		.info                 (info)
	);

	abg_regmem u_regmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (mem_rdata)
	);

	// Control register bit 6 is held in a flop; patch it into the read byte
	always_comb begin
		mem_val = mem_rdata;
		if (info_s1.ovl_ctl) begin
			mem_val[CTL_CMD_BIT] = info_s1.ctl_bit;
		end
		if (!info_s1.mem_rd) begin
			rd_val = info_s1.rd;
		end else if (info_s1.kbd) begin
			rd_val = {info_s1.kbd_full, mem_val[6:0]};
		end else begin
			rd_val = mem_val;
		end
	end

	// Forward a latch load into the item entering this cycle
	assign fwd.valid = s1_adv & info_s1.ld_latch;
	assign fwd.data  = mem_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_tdata_q <= {5'd0, info_s1.option_key, info_s1.command_key,
			              info_s1.line_release, rd_val};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Memory port carries at most one access per item
	assert property (@(posedge clk) disable iff (!arst_n) !(req.re && req.we))
		else $error("register memory read and write in the same cycle");

	// No memory access without an accepted item
	assert property (@(posedge clk) disable iff (!arst_n) (req.re || req.we) |-> accept)
		else $error("register memory access without input transfer");

	// A stalled read stage keeps its item
	assert property (@(posedge clk) disable iff (!arst_n) (valid_s1 && !advance) |=> valid_s1)
		else $error("read stage item dropped while stalled");

	// An accepted item lands in the read stage
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> valid_s1)
		else $error("accepted item lost");

endmodule
